// ===== design/cte_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock time/date editor package
// Shared types and codes for the time and date set editor.
// ----------------------------------------------------------------------------
`default_nettype none

package cte_pkg;

    // Event codes carried by one input word.
    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_UP     = 2'd1,
        CMD_DOWN   = 2'd2,
        CMD_SAMPLE = 2'd3
    } t_cmd;

    // Field cursor; CUR_NONE means view mode.
    typedef enum logic [2:0] {
        CUR_HOUR    = 3'd0,
        CUR_MINUTE  = 3'd1,
        CUR_SECOND  = 3'd2,
        CUR_WEEKDAY = 3'd3,
        CUR_DATE    = 3'd4,
        CUR_MONTH   = 3'd5,
        CUR_YEAR    = 3'd6,
        CUR_NONE    = 3'd7
    } t_cursor;

    typedef struct packed {
        t_cmd        cmd;
        logic [4:0]  sample_hour;
        logic [5:0]  sample_minute;
        logic [5:0]  sample_second;
        logic [2:0]  sample_weekday;
        logic [4:0]  sample_date;
        logic [3:0]  sample_month;
        logic [6:0]  sample_year;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [6:0]  year;
        logic        editing;
        t_cursor     cursor;
        logic        commit;
    } t_out_word;

    // Held editor state: seven values and the cursor.
    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [4:0]  date;
        logic [3:0]  month;
        logic [6:0]  year;
        t_cursor     cursor;
    } t_held;

endpackage

`default_nettype wire

// ===== design/cte_if.sv =====
// ----------------------------------------------------------------------------
// Clock time/date editor channels
// Valid/ready channels for event words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cte_in_if;
    logic              valid;
    logic              ready;
    cte_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cte_out_if;
    logic               valid;
    logic               ready;
    cte_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cte_update.sv =====
// ----------------------------------------------------------------------------
// Clock time/date editor update logic
// Next held state and commit strobe for one event word.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_update (
    input  cte_pkg::t_in_word i_word,
    input  cte_pkg::t_held    i_state,
    output cte_pkg::t_held    o_state,
    output logic              o_commit
);
    import cte_pkg::*;

    logic       editing;
    logic [5:0] hour_inc;
    logic [6:0] minute_inc;
    logic [6:0] second_inc;

    assign editing    = (i_state.cursor != CUR_NONE);
    assign hour_inc   = {1'b0, i_state.hour} + 6'd1;
    assign minute_inc = {1'b0, i_state.minute} + 7'd1;
    assign second_inc = {1'b0, i_state.second} + 7'd1;

    always_comb begin
        o_state  = i_state;
        o_commit = 1'b0;
        case (i_word.cmd)
            CMD_SET: begin
                if (i_state.cursor == CUR_NONE) begin
                    o_state.cursor = CUR_HOUR;
                end else if (i_state.cursor == CUR_YEAR) begin
                    o_state.cursor = CUR_NONE;
                    o_commit       = 1'b1;
                end else begin
                    o_state.cursor = t_cursor'(i_state.cursor + 3'd1);
                end
            end
            CMD_UP: begin
                case (i_state.cursor)
                    CUR_HOUR: o_state.hour = (hour_inc >= 6'd24)
                        ? 5'(hour_inc - 6'd24) : hour_inc[4:0];
                    CUR_MINUTE: o_state.minute = (minute_inc >= 7'd60)
                        ? 6'(minute_inc - 7'd60) : minute_inc[5:0];
                    CUR_SECOND: o_state.second = (second_inc >= 7'd60)
                        ? 6'(second_inc - 7'd60) : second_inc[5:0];
                    CUR_WEEKDAY: o_state.weekday = (i_state.weekday == 3'd7)
                        ? 3'd1 : i_state.weekday + 3'd1;
                    CUR_DATE: o_state.date = (i_state.date < 5'd31)
                        ? i_state.date + 5'd1 : 5'd1;
                    CUR_MONTH: o_state.month = (i_state.month < 4'd12)
                        ? i_state.month + 4'd1 : 4'd1;
                    CUR_YEAR: o_state.year = (i_state.year < 7'd99)
                        ? i_state.year + 7'd1 : 7'd0;
                    default: ;
                endcase
            end
            CMD_DOWN: begin
                case (i_state.cursor)
                    CUR_HOUR: o_state.hour = (i_state.hour > 5'd0)
                        ? i_state.hour - 5'd1 : 5'd23;
                    CUR_MINUTE: o_state.minute = (i_state.minute > 6'd0)
                        ? i_state.minute - 6'd1 : 6'd59;
                    CUR_SECOND: o_state.second = (i_state.second > 6'd0)
                        ? i_state.second - 6'd1 : 6'd59;
                    CUR_WEEKDAY: o_state.weekday = (i_state.weekday > 3'd1)
                        ? i_state.weekday - 3'd1 : 3'd7;
                    CUR_DATE: o_state.date = (i_state.date > 5'd1)
                        ? i_state.date - 5'd1 : 5'd31;
                    CUR_MONTH: o_state.month = (i_state.month > 4'd1)
                        ? i_state.month - 4'd1 : 4'd12;
                    CUR_YEAR: o_state.year = (i_state.year > 7'd0)
                        ? i_state.year - 7'd1 : 7'd99;
                    default: ;
                endcase
            end
            CMD_SAMPLE: begin
                // Samples from the clock chip only land in view mode.
                if (!editing) begin
                    o_state.hour    = i_word.sample_hour;
                    o_state.minute  = i_word.sample_minute;
                    o_state.second  = i_word.sample_second;
                    o_state.weekday = i_word.sample_weekday;
                    o_state.date    = i_word.sample_date;
                    o_state.month   = i_word.sample_month;
                    o_state.year    = i_word.sample_year;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/clock_time_date_set_editor.sv =====
// ----------------------------------------------------------------------------
// Clock time and date set editor
// Button-driven editor for the seven time/date values of a clock chip.
// ----------------------------------------------------------------------------
// Usage: i_in carries one event word per handshake: a set, up or down press,
// or a time sample from the clock chip. o_out carries exactly one result word
// per event: the held values after the event, the cursor, the editing flag
// and a one-word commit strobe raised by the set press that leaves year.
// The result register loads at the edge that accepts an event, so its result
// word shows on o_out right after that edge. Throughput is one word per cycle
// while o_out.ready is high, set by the single result register: a new event is
// taken in the same cycle the previous result is taken, so ready is low only
// while a result waits and the receiver holds o_out.ready low.
// Reset (i_rst_n low, synchronous) empties the result register, puts the
// cursor in view mode and clears all held values to zero.
// While the receiver stalls, the result word holds and i_in.ready stays low;
// no event is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_time_date_set_editor (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cte_in_if.sink     i_in,
    cte_out_if.source  o_out
);
    import cte_pkg::*;

    t_held     r_held;
    t_held     n_held;
    logic      n_commit;
    t_out_word r_out;
    logic      r_out_valid;
    logic      accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    cte_update u_update (
        .i_word   (i_in.data),
        .i_state  (r_held),
        .o_state  (n_held),
        .o_commit (n_commit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '{hour: '0, minute: '0, second: '0, weekday: '0,
                             date: '0, month: '0, year: '0, cursor: CUR_NONE};
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_held <= n_held;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.hour         <= n_held.hour;
            r_out.minute       <= n_held.minute;
            r_out.second       <= n_held.second;
            r_out.weekday      <= n_held.weekday;
            r_out.day_of_month <= n_held.date;
            r_out.month        <= n_held.month;
            r_out.year         <= n_held.year;
            r_out.editing      <= (n_held.cursor != CUR_NONE);
            r_out.cursor       <= n_held.cursor;
            r_out.commit       <= n_commit;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

// ===== design/cte_checker.sv =====
// ----------------------------------------------------------------------------
// Clock time/date editor port checker
// Concurrent checks on the top level's channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  wire        i_out_editing,
    input  wire [2:0]  i_out_cursor,
    input  wire        i_out_commit
);
    import cte_pkg::*;

    // A waiting result word must not vanish before it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word dropped while stalled");

    // Every accepted event yields a result word on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted event produced no result word");

    // Input side is blocked exactly when a result waits on a stalled receiver.
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output slot");

    // A commit always lands back in view mode.
    a_commit_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_commit) |->
            (i_out_cursor == CUR_NONE && !i_out_editing))
        else $error("commit without return to view mode");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

endmodule

bind clock_time_date_set_editor cte_checker u_cte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_editing (o_out.data.editing),
    .i_out_cursor  (o_out.data.cursor),
    .i_out_commit  (o_out.data.commit)
);

`default_nettype wire
